// ----- design/hit_rate_trip_detector_core_macros.svh -----
// Assertion macros shared by the checker.
`ifndef HIT_RATE_TRIP_DETECTOR_CORE_MACROS_SVH
`define HIT_RATE_TRIP_DETECTOR_CORE_MACROS_SVH

// Implication checked in the same cycle, masked while reset is asserted.
`define HTD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Implication checked in the cycle after the antecedent, masked while reset is asserted.
`define HTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ----- design/htd_pkg.sv -----
`timescale 1ns / 1ps
package htd_pkg;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_SKIPPED  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ABS_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REL_FACT  = 1'd1;

    localparam logic FUNC_EVENT  = 1'b0;
    localparam logic FUNC_RECORD = 1'b1;

    typedef logic [31:0] t_word;
    typedef logic [63:0] t_prod;
endpackage

// ----- design/hit_rate_trip_detector_core.sv -----
`timescale 1ns / 1ps
// Per-channel trip detector. Event-start words and records that are rejected or
// skipped are answered straight from the idle state. A good channel record steps
// through S_RD, S_ROW, S_K, S_E and S_R, then an S_L/S_H pair per bin test, left
// early once a test fails, and S_WB. Its pace is set by one registered 32x32
// multiplier, shared for the rate limit, the elapsed time and two partial products
// per bin test. A result word that is not taken holds the block until it drains.
// After reset, a clearing pass zeroes every row of the channel memory before the
// first word is accepted. Bins are shifted lazily: each channel row carries the
// bin number at which it was last written.
module hit_rate_trip_detector_core #(
    parameter int CHANNELS    = 8192,
    parameter int BINS_KEPT   = 4,
    parameter int BIN_SECONDS = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [htd_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [htd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [30:0] timestamp, [43:31] channel, [53:44] hit_count, [54] channel_good
    input  logic [htd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] func
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [1:0] status, [2] new_bin, [3] tripped, [27:4] trip_hits
    output logic [htd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import htd_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IW = $clog2(BINS_KEPT);
    localparam int CB = BINS_KEPT * 24;
    localparam int RW = CB + 64;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_ROW  = 4'd2;
    localparam logic [3:0] S_K    = 4'd3;
    localparam logic [3:0] S_E    = 4'd4;
    localparam logic [3:0] S_R    = 4'd5;
    localparam logic [3:0] S_L    = 4'd6;
    localparam logic [3:0] S_H    = 4'd7;
    localparam logic [3:0] S_WB   = 4'd8;

    logic [3:0]    r_state;
    logic          r_clearing;
    logic [AW-1:0] r_clr;
    logic [15:0]   r_abs;
    logic [11:0]   r_rf;
    logic [31:0]   r_prev, r_first, r_cur, r_epoch;
    logic          r_rej;
    logic [AW-1:0] r_addr;
    logic [9:0]    r_nh;
    logic [RW-1:0] r_rd;
    logic [23:0]   r_bins [BINS_KEPT];
    logic [24:0]   r_cnt [4];
    logic [31:0]   r_total, r_k;
    logic [39:0]   r_e;
    logic [63:0]   r_r, r_lo;
    logic [1:0]    r_i;
    logic          r_ok, r_absok;
    logic          r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;

    logic [RW-1:0] mem [CHANNELS];

    t_word mul_a, mul_b;
    t_prod mul_p;

    htd_mul u_mul (.i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_p(mul_p));

    logic          out_free;
    logic [30:0]   in_time;
    logic [12:0]   in_chan;
    logic [31:0]   in_chan_ext;
    logic [9:0]    in_hits;
    logic          in_good;
    logic          acc;
    logic          ev_back;
    logic          ev_new;
    logic          out_set;
    logic          n_ovalid;
    logic [23:0]   sh [BINS_KEPT];
    logic [31:0]   lag, src;
    logic [23:0]   cur_sat;
    logic [32:0]   tot_sum;
    logic [71:0]   full;
    logic          last_done;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [RW-1:0] mem_wd;

    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && !r_clearing && out_free;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign in_time       = s_axis_tdata[30:0];
    assign in_chan       = s_axis_tdata[43:31];
    assign in_hits       = s_axis_tdata[53:44];
    assign in_good       = s_axis_tdata[54];
    assign in_chan_ext   = 32'(in_chan);
    assign ev_back       = 32'(in_time) < r_prev;
    assign ev_new        = (32'(in_time) - r_prev) > 32'(BIN_SECONDS);
    assign out_set       = ((r_state == S_IDLE) && acc &&
                            (s_axis_tuser == FUNC_EVENT || r_rej || !in_good ||
                             in_chan_ext >= 32'(CHANNELS))) ||
                           ((r_state == S_WB) && out_free);
    assign n_ovalid      = out_set || (r_ovalid && !m_axis_tready);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign cur_sat       = r_cnt[0][24] ? 24'hFFFFFF : r_cnt[0][23:0];
    assign tot_sum       = 33'(r_total) + 33'(r_nh);
    assign full          = 72'(r_lo) + {mul_p[39:0], 32'd0};
    assign last_done     = (r_i == 2'd3) || !(full > 72'(r_r));

    // Bring a stored row up to the current bin by dropping the oldest counts.
    always_comb begin
        lag = r_epoch - r_rd[CB+32 +: 32];
        src = '0;
        for (int j = 0; j < BINS_KEPT; j++) begin
            src   = 32'(j) + lag;
            sh[j] = '0;
            if (lag < 32'(BINS_KEPT) && src < 32'(BINS_KEPT)) begin
                sh[j] = r_rd[24*src[IW-1:0] +: 24];
            end
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_ROW: begin
                mul_a = 32'(r_rf);
                mul_b = 32'(BIN_SECONDS * 100);
            end
            S_K: begin
                mul_a = r_cur - r_first;
                mul_b = 32'd100;
            end
            S_E: begin
                mul_a = r_k;
                mul_b = r_total;
            end
            S_R: begin
                mul_a = {3'd0, r_cnt[0], 4'd0};
                mul_b = r_e[31:0];
            end
            S_L: begin
                mul_a = {3'd0, r_cnt[r_i], 4'd0};
                mul_b = 32'(r_e[39:32]);
            end
            S_H: begin
                mul_a = {3'd0, r_cnt[r_i + 2'd1], 4'd0};
                mul_b = r_e[31:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_addr;
        mem_wd = '0;
        if (r_clearing) begin
            mem_we = 1'b1;
            mem_wa = r_clr;
        end else if (r_state == S_WB && out_free) begin
            mem_we = 1'b1;
            for (int j = 0; j < BINS_KEPT; j++) begin
                mem_wd[24*j +: 24] = r_bins[j];
            end
            mem_wd[24*(BINS_KEPT-1) +: 24] = cur_sat;
            mem_wd[CB +: 32]      = tot_sum[32] ? 32'hFFFFFFFF : tot_sum[31:0];
            mem_wd[CB+32 +: 32]   = r_epoch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_clearing <= 1'b1;
            r_clr      <= '0;
            r_abs      <= '0;
            r_rf       <= '0;
            r_prev     <= '0;
            r_first    <= 32'hFFFFFFFF;
            r_cur      <= '0;
            r_epoch    <= '0;
            r_rej      <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_ABS_LIMIT) begin
                    r_abs <= i_cfg_data;
                end else if (i_cfg_addr == REG_REL_FACT) begin
                    r_rf <= i_cfg_data[11:0];
                end
            end
            if (r_clearing) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == AW'(CHANNELS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            r_ovalid <= n_ovalid;
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        if (s_axis_tuser == FUNC_EVENT) begin
                            r_odata <= ev_back ? 32'(ST_REJECTED) : {29'd0, ev_new, ST_OK};
                            if (ev_back) begin
                                r_rej <= 1'b1;
                            end else begin
                                r_rej <= 1'b0;
                                r_cur <= 32'(in_time);
                                if (r_first > 32'(in_time)) begin
                                    r_first <= 32'(in_time);
                                end
                                if (ev_new) begin
                                    r_epoch <= r_epoch + 32'd1;
                                    r_prev  <= 32'(in_time);
                                end
                            end
                        end else if (r_rej) begin
                            r_odata  <= 32'(ST_REJECTED);
                        end else if (!in_good || in_chan_ext >= 32'(CHANNELS)) begin
                            r_odata  <= 32'(ST_SKIPPED);
                        end else begin
                            r_addr  <= in_chan_ext[AW-1:0];
                            r_nh    <= in_hits;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: r_state <= S_ROW;
                S_ROW: begin
                    for (int j = 0; j < BINS_KEPT; j++) begin
                        r_bins[j] <= sh[j];
                    end
                    r_cnt[0] <= 25'(sh[BINS_KEPT-1]) + 25'(r_nh);
                    r_cnt[1] <= 25'(sh[BINS_KEPT-2]);
                    r_cnt[2] <= 25'(sh[BINS_KEPT-3]);
                    r_cnt[3] <= 25'(sh[BINS_KEPT-4]);
                    r_absok  <= (32'(sh[BINS_KEPT-1]) + 32'(r_nh)) >
                                (32'(r_abs) * 32'(BIN_SECONDS));
                    r_total  <= r_rd[CB +: 32];
                    r_state  <= S_K;
                end
                S_K: begin
                    r_k     <= mul_p[31:0];
                    r_state <= S_E;
                end
                S_E: begin
                    // Elapsed time in hundredths of a second, plus one.
                    r_e     <= (r_cur >= r_first) ? (mul_p[39:0] + 40'd1) : 40'd1;
                    r_state <= S_R;
                end
                S_R: begin
                    r_r     <= mul_p;
                    r_i     <= 2'd0;
                    r_ok    <= 1'b1;
                    r_state <= S_L;
                end
                S_L: begin
                    r_lo    <= mul_p;
                    r_state <= S_H;
                end
                S_H: begin
                    // Count test: 16*c*E > limit term, built from two products.
                    if (!(full > 72'(r_r))) begin
                        r_ok <= 1'b0;
                    end
                    if (last_done) begin
                        r_state <= S_WB;
                    end else begin
                        r_i     <= r_i + 2'd1;
                        r_state <= S_L;
                    end
                end
                S_WB: begin
                    if (out_free) begin
                        r_odata <= (r_ok && r_absok) ?
                                   {4'd0, cur_sat, 1'b1, 1'b0, ST_OK} : 32'(ST_OK);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- design/htd_mul.sv -----
`timescale 1ns / 1ps
module htd_mul (
    input  logic           i_clk,
    input  htd_pkg::t_word i_a,
    input  htd_pkg::t_word i_b,
    output htd_pkg::t_prod o_p
);
    import htd_pkg::*;

    t_prod r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;
endmodule

// ----- design/htd_checker.sv -----
`timescale 1ns / 1ps
`include "hit_rate_trip_detector_core_macros.svh"
module htd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [htd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import htd_pkg::*;

    // A stalled result word keeps its value.
    `HTD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // After an accepted word the block either holds a result or stays busy.
    `HTD_ASSERT_NEXT(a_busy_after, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready || m_axis_tvalid)
    // A rejected word carries no other information.
    `HTD_ASSERT_NOW(a_rej_clean, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[1:0] == ST_REJECTED, m_axis_tdata[27:2] == 26'd0)
    // A trip is only reported on an accepted record with a nonzero count.
    `HTD_ASSERT_NOW(a_trip_ok, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[3], m_axis_tdata[1:0] == ST_OK && m_axis_tdata[27:4] != 24'd0)
endmodule

bind hit_rate_trip_detector_core htd_checker u_htd_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

// ----- tb/sv/tb_hit_rate_trip_detector_core.sv -----
`timescale 1ns / 1ps
module tb_hit_rate_trip_detector_core;
    import htd_pkg::*;

    localparam int NCH   = 8192;
    localparam int NBIN  = 4;
    localparam int BIN_S = 5;

    // Laid out as on m_axis_tdata, lowest field last.
    typedef struct packed {
        logic [23:0] trip_hits;
        logic        tripped;
        logic        new_bin;
        logic [1:0]  status;
    } t_verdict;

    typedef struct {
        logic        func;
        logic [30:0] ts;
        logic [12:0] ch;
        logic [9:0]  hits;
        logic        good;
        bit          typed;
        t_verdict    want;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    hit_rate_trip_detector_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // Shadow copy of the detector state.
    logic [23:0] bin_hist [NCH][NBIN];
    logic [31:0] hit_total [NCH];
    logic [31:0] bin_open_time;
    logic [31:0] start_time;
    logic [31:0] now_time;
    bit          evt_rejected;
    logic [15:0] abs_limit;
    logic [11:0] rel_factor;

    t_verdict    pending_verdicts[$];
    int          errors;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void queue_verdict(t_verdict v);
        pending_verdicts = {pending_verdicts, v};
    endfunction

    function automatic bit beats_relative(logic [63:0] cnt, logic [63:0] elapsed,
                                          logic [31:0] total);
        logic [63:0] lhs;
        logic [63:0] rhs;
        lhs = cnt * 64'd16;
        rhs = 64'(rel_factor) * 64'd100 * 64'(BIN_S) * 64'(total);
        if (lhs == 64'd0) return 1'b0;
        return elapsed > rhs / lhs;
    endfunction

    // Advances the shadow state by one word and returns the verdict it gives.
    function automatic t_verdict judge_word(logic func, logic [30:0] ts, logic [12:0] ch,
                                            logic [9:0] hits, logic good);
        t_verdict    v;
        logic [31:0] t;
        logic [63:0] elapsed;
        logic [63:0] cur;
        logic [32:0] sum;
        v = '0;
        if (func == FUNC_EVENT) begin
            t = {1'b0, ts};
            if (t < bin_open_time) begin
                evt_rejected = 1'b1;
                v.status = ST_REJECTED;
                return v;
            end
            evt_rejected = 1'b0;
            now_time = t;
            if (start_time > t) start_time = t;
            if (t - bin_open_time > 32'(BIN_S)) begin
                for (int c = 0; c < NCH; c++) begin
                    for (int b = 0; b < NBIN - 1; b++) bin_hist[c][b] = bin_hist[c][b+1];
                    bin_hist[c][NBIN-1] = '0;
                end
                bin_open_time = t;
                v.new_bin = 1'b1;
            end
            return v;
        end
        if (evt_rejected) begin
            v.status = ST_REJECTED;
            return v;
        end
        if (!good) begin
            v.status = ST_SKIPPED;
            return v;
        end
        elapsed = 64'd1;
        if (now_time >= start_time) elapsed = 64'(now_time - start_time) * 64'd100 + 64'd1;
        cur = 64'(bin_hist[ch][NBIN-1]) + 64'(hits);
        if (cur > 64'(abs_limit) * 64'(BIN_S) &&
            beats_relative(cur, elapsed, hit_total[ch]) &&
            beats_relative(64'(bin_hist[ch][NBIN-2]), elapsed, hit_total[ch]) &&
            beats_relative(64'(bin_hist[ch][NBIN-3]), elapsed, hit_total[ch]) &&
            beats_relative(64'(bin_hist[ch][NBIN-4]), elapsed, hit_total[ch])) begin
            v.tripped = 1'b1;
            v.trip_hits = (cur > 64'hFFFFFF) ? 24'hFFFFFF : cur[23:0];
        end
        sum = 33'(hit_total[ch]) + 33'(hits);
        hit_total[ch] = sum[32] ? 32'hFFFFFFFF : sum[31:0];
        bin_hist[ch][NBIN-1] = (cur > 64'hFFFFFF) ? 24'hFFFFFF : cur[23:0];
        return v;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_ABS_LIMIT) abs_limit = val;
        else rel_factor = val[11:0];
        @(posedge i_clk);
    endtask

    task automatic settle_and_config(logic [15:0] lim, logic [11:0] fac);
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        write_reg(REG_ABS_LIMIT, lim);
        write_reg(REG_REL_FACT, {4'd0, fac});
    endtask

    task automatic send_word(logic func, logic [30:0] ts, logic [12:0] ch,
                             logic [9:0] hits, logic good, bit typed, t_verdict want);
        t_verdict v;
        bit       fire;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {1'b0, good, hits, ch, ts};
        // The ready level is stable by the falling edge, ahead of the sampling edge.
        forever begin
            @(negedge i_clk);
            fire = s_axis_tready;
            @(posedge i_clk);
            if (fire) break;
        end
        v = judge_word(func, ts, ch, hits, good);
        queue_verdict(typed ? want : v);
    endtask

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_verdict got;
        t_verdict exp_v;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[27:0];
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected word, actual %h", $realtime, got);
                errors++;
            end else begin
                exp_v = pending_verdicts.pop_front();
                if (got.status !== exp_v.status || got.new_bin !== exp_v.new_bin ||
                    got.tripped !== exp_v.tripped || got.trip_hits !== exp_v.trip_hits) begin
                    $display("%0t: mismatch, expected st=%0d nb=%0d tr=%0d hits=%0d, actual st=%0d nb=%0d tr=%0d hits=%0d",
                             $realtime, exp_v.status, exp_v.new_bin, exp_v.tripped,
                             exp_v.trip_hits, got.status, got.new_bin, got.tripped,
                             got.trip_hits);
                    errors++;
                end
            end
        end
    end

    function automatic t_stim_row mk(logic func, logic [30:0] ts, logic [12:0] ch,
                                     logic [9:0] hits, logic good, bit typed,
                                     logic [1:0] st, logic nb);
        t_stim_row r;
        r.func = func; r.ts = ts; r.ch = ch; r.hits = hits; r.good = good;
        r.typed = typed;
        r.want = '0;
        r.want.status = st;
        r.want.new_bin = nb;
        return r;
    endfunction

    initial begin
        t_stim_row   rows[18];
        logic [30:0] tnext;
        logic [12:0] ch;
        int          pick;
        int          cfg_lim[4];
        int          cfg_fac[4];
        int          idle_s[4];
        int          idle_r[4];

        errors = 0;
        hold_req = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = FUNC_EVENT;
        for (int c = 0; c < NCH; c++) begin
            hit_total[c] = '0;
            for (int b = 0; b < NBIN; b++) bin_hist[c][b] = '0;
        end
        bin_open_time = '0;
        start_time = 32'hFFFFFFFF;
        now_time = '0;
        evt_rejected = 1'b0;
        abs_limit = '0;
        rel_factor = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Record ahead of any event, empty bins, skipped and rejected records, then
        // four bins on channel 2 so that it trips with both limits at zero.
        rows = '{
            mk(FUNC_RECORD, 0, 0, 5, 1, 1, ST_OK, 0),
            mk(FUNC_EVENT, 0, 0, 0, 0, 1, ST_OK, 0),
            mk(FUNC_RECORD, 0, 2, 100, 1, 0, ST_OK, 0),
            mk(FUNC_EVENT, 6, 0, 0, 0, 1, ST_OK, 1),
            mk(FUNC_RECORD, 0, 8191, 1023, 0, 1, ST_SKIPPED, 0),
            mk(FUNC_RECORD, 0, 8191, 1023, 1, 0, ST_OK, 0),
            mk(FUNC_RECORD, 0, 2, 100, 1, 0, ST_OK, 0),
            mk(FUNC_EVENT, 3, 0, 0, 0, 1, ST_REJECTED, 0),
            mk(FUNC_RECORD, 0, 2, 100, 1, 1, ST_REJECTED, 0),
            mk(FUNC_RECORD, 0, 1, 7, 0, 1, ST_REJECTED, 0),
            mk(FUNC_EVENT, 11, 0, 0, 0, 1, ST_OK, 0),
            mk(FUNC_RECORD, 0, 2, 100, 1, 0, ST_OK, 0),
            mk(FUNC_EVENT, 12, 0, 0, 0, 1, ST_OK, 1),
            mk(FUNC_RECORD, 0, 2, 1023, 1, 0, ST_OK, 0),
            mk(FUNC_EVENT, 18, 0, 0, 0, 1, ST_OK, 1),
            mk(FUNC_RECORD, 0, 2, 0, 1, 0, ST_OK, 0),
            mk(FUNC_RECORD, 0, 2, 1, 1, 0, ST_OK, 0),
            mk(FUNC_RECORD, 0, 8191, 0, 1, 0, ST_OK, 0)
        };
        foreach (rows[i])
            send_word(rows[i].func, rows[i].ts, rows[i].ch, rows[i].hits, rows[i].good,
                      rows[i].typed, rows[i].want);

        cfg_lim = '{0, 65535, 3, 20};
        cfg_fac = '{0, 4095, 16, 1};
        idle_s  = '{0, 57, 0, 38};
        idle_r  = '{0, 0, 57, 38};
        tnext = 18;
        for (int ph = 0; ph < 4; ph++) begin
            settle_and_config(16'(cfg_lim[ph]), 12'(cfg_fac[ph]));
            send_idle_pct = idle_s[ph];
            recv_stall_pct = idle_r[ph];
            if (ph == 0) hold_req = 1'b1;
            for (int n = 0; n < 120; n++) begin
                pick = $urandom_range(99);
                if (pick < 3) begin
                    // Arbitrary event time, far ahead or behind the current one.
                    send_word(FUNC_EVENT, 31'($urandom_range(32'h7FFFFFFF)) & 31'h3FFFFFFF,
                              0, 0, 0, 0, '0);
                    if (!evt_rejected) tnext = now_time[30:0];
                end else if (pick < 6) begin
                    send_word(FUNC_EVENT, tnext - 31'($urandom_range(6, 1)), 0, 0, 0, 0, '0);
                end else if (pick < 24) begin
                    tnext = tnext + 31'($urandom_range(9));
                    send_word(FUNC_EVENT, tnext, 0, 0, 0, 0, '0);
                end else begin
                    ch = ($urandom_range(9) == 0) ? 13'($urandom_range(8191))
                                                  : 13'($urandom_range(3));
                    send_word(FUNC_RECORD, 31'($urandom_range(32'h7FFFFFFF)), ch,
                              ($urandom_range(3) == 0) ? 10'($urandom_range(1023))
                                                       : 10'($urandom_range(40)),
                              $urandom_range(9) != 0, 0, '0);
                end
            end
        end

        send_word(FUNC_EVENT, 31'h7FFFFFFF, 0, 0, 0, 0, '0);
        send_word(FUNC_RECORD, 31'h7FFFFFFF, 13'h1FFF, 10'h3FF, 1, 0, '0);
        s_axis_tvalid <= 1'b0;

        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+design
design/htd_pkg.sv
design/htd_mul.sv
design/hit_rate_trip_detector_core.sv
design/htd_checker.sv
tb/sv/tb_hit_rate_trip_detector_core.sv
